FILE: sv/flanger_audio_effect_core_defines.svh
// Assertion macros shared by the checker files of the flanger core.
`ifndef FLANGER_AUDIO_EFFECT_CORE_DEFINES_SVH
`define FLANGER_AUDIO_EFFECT_CORE_DEFINES_SVH

// Checked only outside reset.
`define FAE_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FAE_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fae_pkg.sv
// Package with constants, register indexes and helpers of the flanger core.
`timescale 1ns / 1ps
package fae_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int DEF_DELAY_DEPTH  = 512;
  localparam int DEF_SINE_ENTRIES = 1024;
  localparam int MIN_DELAY_Q8     = 1129;
  localparam int MAX_DELAY_Q8     = 90353;
  localparam int SPAN_Q8          = MAX_DELAY_Q8 - MIN_DELAY_Q8;
  localparam int SOFT_A_Q16       = 45875;
  localparam int UNIT_Q16         = 65536;
  localparam int ADDR_W           = 5;
  localparam int HORNER_START     = 172272;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_LFO_STEP = 3'd1,
    REG_MANUAL   = 3'd2,
    REG_DEPTH    = 3'd3,
    REG_FEEDBACK = 3'd4,
    REG_WET      = 3'd5
  } reg_idx_t;

  // Coefficients of the odd sine polynomial, Q2.30, applied from the inside out.
  function automatic logic [30:0] horner_coef(input logic [1:0] k);
    logic [30:0] c;
    unique case (k)
      2'd0: c = 31'd5026995;
      2'd1: c = 31'd85569306;
      2'd2: c = 31'd693598668;
      2'd3: c = 31'd1686629713;
    endcase
    return c;
  endfunction

  // Gains above one are held at one.
  function automatic logic [16:0] cap_unit(input logic [16:0] v);
    return v[16] ? 17'(UNIT_Q16) : v;
  endfunction

endpackage

FILE: sv/flanger_audio_effect_core.sv
// Flanger core: LFO-swept interpolated delay with soft-clipped feedback.
//
//  Channel  Dir  Handshake                    Payload
//  s_*      in   s_tvalid / s_tready          s_tdata[15:0] = sample_in
//  m_*      out  m_tvalid / m_tready          m_tdata[15:0] = sample_out
//  APB      in   psel & penable & pwrite      six registers at 4*index
//
// With the effect enabled each sample is worked through the single shared
// 33x33 multiplier, which every product (sine polynomial, delay sweep,
// interpolation, feedback, cubic clip, mix) visits in turn. Disabled, a
// sample passes through unchanged. After reset the delay store is cleared
// one entry a cycle, with s_tready low. A finished result waits in the
// output register; the next input transfer is taken while it waits.
// DELAY_DEPTH and SINE_ENTRIES are to be powers of two; the core does not check it.
`timescale 1ns / 1ps
module flanger_audio_effect_core
  import fae_pkg::*;
#(
  parameter int DELAY_DEPTH  = DEF_DELAY_DEPTH,
  parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [15:0] sample_in
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // [15:0] sample_out
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SI = $clog2(SINE_ENTRIES);
  localparam int PW = AW + 9;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SQ, S_Z2, S_HM, S_HA, S_ZM, S_R, S_BASE, S_SWEEP,
    S_DLY, S_RD0, S_RD1, S_INTERP, S_FB, S_CUBE, S_SOFT, S_STORE, S_MIX0,
    S_MIX1, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic               enable;
  logic [19:0]        lfo_step;
  logic [16:0]        manual_position;
  logic [16:0]        sweep_depth;
  logic signed [15:0] feedback_gain;
  logic [16:0]        wet_mix;

  // Long-lived state.
  logic [AW-1:0] wp;
  logic [31:0]   phase;
  logic [AW-1:0] clr_addr;

  // Per-sample working registers.
  logic signed [15:0] x;
  logic [1:0]         quad;
  logic [30:0]        z;
  logic [30:0]        z2;
  logic [30:0]        acc;
  logic [1:0]         k;
  logic signed [16:0] lfo;
  logic signed [19:0] base;
  logic [AW-1:0]      i0;
  logic [7:0]         f;
  logic signed [15:0] y0;
  logic signed [16:0] delayed;
  logic signed [16:0] vr;
  logic signed [34:0] wsum;
  logic [15:0]        res;
  logic signed [65:0] prod;

  // Delay store.
  logic [15:0]   store [DELAY_DEPTH];
  logic [15:0]   rdata;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  // Combinational values.
  logic signed [32:0] ma, mb;
  logic [31:0]        u_c;
  logic [30:0]        z_c;
  logic [32:0]        r_c;
  logic [17:0]        r15;
  logic [15:0]        r_cap;
  logic signed [16:0] lfo_c;
  logic [16:0]        man_c, dep_c, wet_c;
  logic signed [23:0] dsum;
  logic [17:0]        delay_c;
  logic [PW-1:0]      pos_c;
  logic signed [17:0] delayed_c;
  logic signed [19:0] vsum;
  logic signed [16:0] v_c;
  logic signed [17:0] v3_c;
  logic signed [24:0] soft_c;
  logic signed [24:0] stored_c;
  logic signed [35:0] ysum;
  logic signed [19:0] yq;
  logic signed [17:0] y_c;
  logic signed [33:0] p_c;
  logic signed [33:0] pn_c;
  logic [15:0]        out_c;
  logic               cfg_wr;

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_ENABLE:   prdata = {31'd0, enable};
      REG_LFO_STEP: prdata = {12'd0, lfo_step};
      REG_MANUAL:   prdata = {15'd0, manual_position};
      REG_DEPTH:    prdata = {15'd0, sweep_depth};
      REG_FEEDBACK: prdata = {{16{feedback_gain[15]}}, feedback_gain};
      REG_WET:      prdata = {15'd0, wet_mix};
      default:      prdata = 32'd0;
    endcase
  end

  // Datapath around the shared multiplier.
  always_comb begin
    man_c = cap_unit(manual_position);
    dep_c = cap_unit(sweep_depth);
    wet_c = cap_unit(wet_mix);

    // Sine table position folded into the first quadrant.
    u_c = {phase[31 -: SI], {(32 - SI){1'b0}}};
    z_c = u_c[30] ? 31'(32'd1073741824 - {2'b00, u_c[29:0]}) : {1'b0, u_c[29:0]};

    r_c   = {1'b0, prod[61:30]} + 33'd16384;
    r15   = r_c[32:15];
    r_cap = (r15 > 18'd32767) ? 16'd32767 : r15[15:0];
    lfo_c = quad[1] ? -$signed({1'b0, r_cap}) : $signed({1'b0, r_cap});

    dsum = 24'(base) + prod[38:15];
    if (dsum < 24'sd0 + 24'(MIN_DELAY_Q8)) begin
      delay_c = 18'(MIN_DELAY_Q8);
    end else if (dsum > 24'(MAX_DELAY_Q8)) begin
      delay_c = 18'(MAX_DELAY_Q8);
    end else begin
      delay_c = dsum[17:0];
    end
    pos_c = {1'b0, wp, 8'h00} + PW'(DELAY_DEPTH * 256) - PW'(delay_c);

    delayed_c = 18'(y0) + prod[25:8];

    vsum = 20'(x) + 20'($signed(prod[33:15]));
    if (vsum > 20'sd32768) begin
      v_c = 17'sd32768;
    end else if (vsum < -20'sd32768) begin
      v_c = -17'sd32768;
    end else begin
      v_c = vsum[16:0];
    end

    v3_c     = prod[47:30];
    soft_c   = prod[40:16];
    stored_c = 25'(vr) - soft_c;

    ysum = 36'(wsum) + 36'($signed(prod[34:0]));
    yq   = ysum[35:16];
    if (yq > 20'sd32768) begin
      y_c = 18'sd32768;
    end else if (yq < -20'sd32768) begin
      y_c = -18'sd32768;
    end else begin
      y_c = yq[17:0];
    end
    p_c  = (34'(y_c) <<< 15) - 34'(y_c);
    pn_c = -p_c;
    out_c = p_c[33] ? 16'(-(pn_c >>> 15)) : 16'(p_c >>> 15);

    ma = '0;
    mb = '0;
    unique case (state)
      S_SQ: begin
        ma = $signed({2'b00, z_c});
        mb = $signed({2'b00, z_c});
      end
      S_HM: begin
        ma = $signed({2'b00, z2});
        mb = $signed({2'b00, acc});
      end
      S_ZM: begin
        ma = $signed({2'b00, z});
        mb = $signed({2'b00, acc});
      end
      S_R: begin
        ma = $signed({16'd0, man_c});
        mb = 33'(SPAN_Q8);
      end
      S_BASE: begin
        ma = $signed({16'd0, dep_c});
        mb = 33'(SPAN_Q8);
      end
      S_SWEEP: begin
        ma = $signed({13'd0, prod[36:17]});
        mb = 33'(lfo);
      end
      S_RD1: begin
        ma = 33'($signed(rdata)) - 33'(y0);
        mb = $signed({25'd0, f});
      end
      S_INTERP: begin
        ma = 33'(feedback_gain);
        mb = 33'(delayed_c);
      end
      S_FB: begin
        ma = 33'(v_c);
        mb = 33'(v_c);
      end
      S_CUBE: begin
        ma = prod[32:0];
        mb = 33'(vr);
      end
      S_SOFT: begin
        ma = 33'(v3_c);
        mb = 33'(SOFT_A_Q16);
      end
      S_STORE: begin
        ma = $signed({16'd0, 17'(UNIT_Q16) - wet_c});
        mb = 33'(x);
      end
      S_MIX0: begin
        ma = $signed({16'd0, wet_c});
        mb = 33'(delayed);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase

    rd_addr   = (state == S_DLY) ? pos_c[AW+7:8] : AW'(i0 + 1'b1);
    mem_we    = (state == S_CLEAR) || (state == S_STORE);
    mem_waddr = (state == S_CLEAR) ? clr_addr : wp;
    mem_wdata = (state == S_CLEAR) ? 16'd0 : stored_c[15:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata <= store[rd_addr];
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      wp              <= '0;
      phase           <= '0;
      m_tvalid        <= 1'b0;
      enable          <= 1'b0;
      lfo_step        <= '0;
      manual_position <= '0;
      sweep_depth     <= '0;
      feedback_gain   <= '0;
      wet_mix         <= '0;
    end else begin
      prod <= ma * mb;

      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[4:2]))
          REG_ENABLE:   enable          <= pwdata[0];
          REG_LFO_STEP: lfo_step        <= pwdata[19:0];
          REG_MANUAL:   manual_position <= pwdata[16:0];
          REG_DEPTH:    sweep_depth     <= pwdata[16:0];
          REG_FEEDBACK: feedback_gain   <= pwdata[15:0];
          REG_WET:      wet_mix         <= pwdata[16:0];
          default: ;
        endcase
      end

      // A new result in S_DONE takes over the output register itself.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= AW'(clr_addr + 1'b1);
          if (clr_addr == AW'(DELAY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            x    <= s_tdata;
            quad <= u_c[31:30];
            z    <= z_c;
            res  <= s_tdata;
            state <= enable ? S_SQ : S_DONE;
          end
        end
        S_SQ: state <= S_Z2;
        S_Z2: begin
          z2    <= prod[60:30];
          acc   <= 31'(HORNER_START);
          k     <= 2'd0;
          state <= S_HM;
        end
        S_HM: state <= S_HA;
        S_HA: begin
          acc <= 31'(horner_coef(k) - prod[60:30]);
          k   <= k + 2'd1;
          state <= (k == 2'd3) ? S_ZM : S_HM;
        end
        S_ZM: state <= S_R;
        S_R: begin
          lfo   <= lfo_c;
          state <= S_BASE;
        end
        S_BASE: begin
          base  <= 20'(MIN_DELAY_Q8) + prod[35:16];
          state <= S_SWEEP;
        end
        S_SWEEP: state <= S_DLY;
        S_DLY: begin
          i0    <= pos_c[AW+7:8];
          f     <= pos_c[7:0];
          state <= S_RD0;
        end
        S_RD0: begin
          y0    <= rdata;
          state <= S_RD1;
        end
        S_RD1: state <= S_INTERP;
        S_INTERP: begin
          delayed <= delayed_c[16:0];
          state   <= S_FB;
        end
        S_FB: begin
          vr    <= v_c;
          state <= S_CUBE;
        end
        S_CUBE: state <= S_SOFT;
        S_SOFT: state <= S_STORE;
        S_STORE: begin
          wp    <= AW'(wp + 1'b1);
          phase <= phase + {12'd0, lfo_step};
          state <= S_MIX0;
        end
        S_MIX0: begin
          wsum  <= prod[34:0];
          state <= S_MIX1;
        end
        S_MIX1: begin
          res   <= out_c;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/fae_chk.sv
// Port-level checker for the flanger core and its bind statement.
`timescale 1ns / 1ps
`include "flanger_audio_effect_core_defines.svh"
module fae_chk
  import fae_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata
);

  // The delay store is being cleared right after reset.
  `FAE_CHECK_ALWAYS(a_clear_after_rst, clk, rst |=> !s_tready, "input ready during store clear")

  `FAE_CHECK_ALWAYS(a_no_out_after_rst, clk, rst |=> !m_tvalid, "result valid after reset")

  // One sample at a time: a transfer makes the core busy.
  `FAE_CHECK(a_busy_after_in, clk, rst, s_tvalid && s_tready |=> !s_tready, "took two samples")

  `FAE_CHECK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind flanger_audio_effect_core fae_chk u_fae_chk (.*);

FILE: tb/tb_flanger_audio_effect_core.sv
// Self-checking testbench of the flanger core: random and directed samples, APB setup.
`timescale 1ns / 1ps
module tb_flanger_audio_effect_core;
  import fae_pkg::*;

  localparam int DEPTH       = 512;
  localparam int SINE_N      = 1024;
  localparam int IDLE_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #4 clk = ~clk;

  flanger_audio_effect_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the effect state and register settings.
  logic signed [15:0] echo_line [DEPTH];
  int unsigned        wr_idx;
  logic [31:0]        phase_acc;
  logic               fx_on;
  logic [19:0]        phase_inc;
  logic [16:0]        centre_pos;
  logic [16:0]        depth_amt;
  logic signed [15:0] fb_amt;
  logic [16:0]        wet_amt;

  logic [15:0] sample_queue[$];    // samples waiting to be offered
  logic [15:0] expected_out[$];    // predicted outputs in order
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          hold_cycles = 0;    // long receiver hold-off request
  int          failures = 0;
  int          quiet_cycles = 0;

  // Floor division by a power of two; arithmetic shift already floors.
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unit_cap(logic [16:0] v);
    return (v > 17'd65536) ? 65536 : longint'(v);
  endfunction

  // Sine in Q1.15 from the odd polynomial evaluated in Q2.30.
  function automatic int sine_of_phase(logic [31:0] ph);
    logic [63:0] idx, u, z, z2, s, r;
    logic [1:0]  quad;
    idx  = (64'(ph) * SINE_N) >> 32;
    u    = (idx << 32) / SINE_N;
    quad = u[31:30];
    z    = u & 64'h3FFF_FFFF;
    if (quad[0]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    s  = 64'd172272;
    s  = 64'd5026995    - ((z2 * s) >> 30);
    s  = 64'd85569306   - ((z2 * s) >> 30);
    s  = 64'd693598668  - ((z2 * s) >> 30);
    s  = 64'd1686629713 - ((z2 * s) >> 30);
    r  = (z * s) >> 30;
    r  = (r + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return quad[1] ? -int'(r) : int'(r);
  endfunction

  // Works out one output sample and advances the local state.
  function automatic logic [15:0] flange_sample(logic [15:0] din);
    longint x, span, base, sweep, dly, dl, v, v3, y, p, wet, pos, y0, y1, f;
    int     i0, i1;
    x = longint'($signed(din));
    if (!fx_on) return din;
    span  = MAX_DELAY_Q8 - MIN_DELAY_Q8;
    base  = MIN_DELAY_Q8 + fshift(unit_cap(centre_pos) * span, 16);
    sweep = fshift(unit_cap(depth_amt) * span, 17);
    dly   = base + fshift(sweep * sine_of_phase(phase_acc), 15);
    if (dly < MIN_DELAY_Q8) dly = MIN_DELAY_Q8;
    if (dly > MAX_DELAY_Q8) dly = MAX_DELAY_Q8;
    pos = longint'(wr_idx) * 256 + DEPTH * 256 - dly;
    i0  = int'((pos >> 8) % DEPTH);
    i1  = (i0 + 1) % DEPTH;
    f   = pos & 255;
    y0  = echo_line[i0];
    y1  = echo_line[i1];
    dl  = y0 + fshift((y1 - y0) * f, 8);
    v   = x + fshift(longint'(fb_amt) * dl, 15);
    if (v > 32768) v = 32768;
    if (v < -32768) v = -32768;
    v3 = fshift(v * v * v, 30);
    v  = v - fshift(longint'(SOFT_A_Q16) * v3, 16);
    echo_line[wr_idx] = 16'(v);
    wr_idx = (wr_idx + 1) % DEPTH;
    wet = unit_cap(wet_amt);
    y = fshift((65536 - wet) * x + wet * dl, 16);
    if (y > 32768) y = 32768;
    if (y < -32768) y = -32768;
    phase_acc = phase_acc + 32'(phase_inc);
    p = y * 32767;
    y = (p >= 0) ? (p >>> 15) : -((-p) >>> 15);
    return 16'(y);
  endfunction

  // Register write over APB: setup cycle, then access cycle.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:   fx_on      = val[0];
      REG_LFO_STEP: phase_inc  = val[19:0];
      REG_MANUAL:   centre_pos = val[16:0];
      REG_DEPTH:    depth_amt  = val[16:0];
      REG_FEEDBACK: fb_amt     = val[15:0];
      REG_WET:      wet_amt    = val[16:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic en, logic [19:0] inc, logic [16:0] man,
                               logic [16:0] dep, logic [15:0] fb, logic [16:0] wet);
    reg_write(REG_ENABLE, 32'(en));
    reg_write(REG_LFO_STEP, 32'(inc));
    reg_write(REG_MANUAL, 32'(man));
    reg_write(REG_DEPTH, 32'(dep));
    reg_write(REG_FEEDBACK, 32'(fb));
    reg_write(REG_WET, 32'(wet));
  endtask

  // Waits until every sample is offered and every output checked, then lets
  // the block settle before the next register write.
  task automatic drain;
    while (sample_queue.size() != 0 || s_tvalid || expected_out.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Mostly mid-range audio with full-scale hits mixed in.
  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r < 5) return 16'($urandom);
    return 16'($signed($urandom_range(0, 16000)) - 8000);
  endfunction

  // Driver: offers queued samples, keeping tvalid high until the transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_out.push_back(flange_sample(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transfer with the oldest prediction and
  // drives tready, including the long hold-off that fills the pipeline.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $error("unexpected output sample_out=%0d", $signed(m_tdata));
          failures++;
        end else begin
          logic [15:0] want;
          want = expected_out.pop_front();
          if (want !== m_tdata) begin
            $error("sample_out expected %0d actual %0d", $signed(want), $signed(m_tdata));
            failures++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog: stops a run where no transfer happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) echo_line[i] = '0;
    wr_idx = 0; phase_acc = '0;
    fx_on = 1'b0; phase_inc = '0; centre_pos = '0; depth_amt = '0;
    fb_amt = '0; wet_amt = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Bypass with reset settings: extremes pass through untouched.
    sample_queue = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555};
    drain();

    // Full wet, strongest positive feedback, full sweep at a fast LFO.
    apply_setting(1'b1, 20'hFFFFF, 17'd65536, 17'd65536, 16'h7FFF, 17'd65536);
    for (int i = 0; i < 12; i++)
      sample_queue.push_back(i[0] ? 16'h7FFF : 16'h8000);
    drain();

    // Gains and manual position above one, most negative feedback.
    apply_setting(1'b1, 20'd1, 17'h1FFFF, 17'h1FFFF, 16'h8000, 17'h1FFFF);
    for (int i = 0; i < 6; i++) sample_queue.push_back(rand_sample());
    drain();

    // Write to an address outside the register map must change nothing.
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(28); pwdata <= '1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;

    // Random phases with changing settings and idling profiles.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin sender_idle_pct = 34; receiver_idle_pct = 82; end
        1: begin sender_idle_pct = 82; receiver_idle_pct = 34; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      apply_setting(ph != 5, 20'($urandom), 17'($urandom_range(0, 70000)),
                    17'($urandom_range(0, 70000)), 16'($urandom),
                    17'($urandom_range(0, 70000)));
      for (int i = 0; i < 70; i++) sample_queue.push_back(rand_sample());
      if (ph == 2) begin
        repeat (20) @(posedge clk);
        hold_cycles = 400;
      end
      drain();
    end

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: flanger_audio_effect_core.f
+incdir+sv
sv/fae_pkg.sv
sv/flanger_audio_effect_core.sv
sv/fae_chk.sv
tb/tb_flanger_audio_effect_core.sv
